[rtl/core/bsrgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsrgb_pkg;

   localparam int STORE_WIDTH  = 32;
   localparam int STORE_HEIGHT = 48;

   localparam int COLOR_W = 24;
   localparam int INDEX_W = 11;
   localparam int LINES_W = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [COLOR_W-1:0] PAL0_RESET = 24'hff00ff;
   localparam logic [LINES_W-1:0] LINES_RESET = 6'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAL0   = 3'd0,
      CSR_PAL1   = 3'd1,
      CSR_PAL2   = 3'd2,
      CSR_PAL3   = 3'd3,
      CSR_WIDE   = 3'd4,
      CSR_LINES  = 3'd5,
      CSR_DOUBLE = 3'd6,
      CSR_HIRES  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [3:0][COLOR_W-1:0] palette;
      logic                    width_is_32;
      logic [LINES_W-1:0]      sprite_lines;
      logic                    double_mode;
      logic                    hires_source;
   } cfg_type;

   // one decoded line waiting for pixel emission
   typedef struct packed {
      logic [7:0][7:0]    bytes;
      logic [LINES_W-1:0] src_line;
      logic               long_line;   // planes of 4 bytes
      logic               dbl;
      logic               wide;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/core/bsrgb_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bsrgb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_image;

   modport source (output valid, output data_byte, output new_image, input ready);
   modport sink   (input valid, input data_byte, input new_image, output ready);
endinterface

interface bsrgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] pixel_index;
   logic [23:0] pixel_color;
   logic        last;

   modport source (output valid, output pixel_index, output pixel_color, output last,
                   input ready);
   modport sink   (input valid, input pixel_index, input pixel_color, input last,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/bitplane_sprite_to_rgb_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    data_byte[7:0], new_image
// rsp_ch   out  valid/ready    pixel_index[10:0], pixel_color[23:0], last
// csr_*    in   csr_we         csr_index[2:0], csr_wdata[23:0]
//
// A request is taken each cycle while the two-line job queue has room; only the
// request that ends a visible line enqueues work.
// The pixel engine emits one pixel per cycle while rsp_ch is ready, 16, 32 or 64
// per line, and loads the next job only after it has issued the last pixel of a
// line; that loop sets the sustained rate. Reset restores the register defaults and
// empties the queue and output register. rsp_ch stalls hold the engine; req_ch
// stalls only once two lines are queued.

module bitplane_sprite_to_rgb_core (
   input  wire logic        clock,
   input  wire logic        reset,
   bsrgb_req_if.sink        req_ch,
   bsrgb_rsp_if.source      rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import bsrgb_pkg::*;

   cfg_type          cfg_ff;
   job_type          push_job, pop_job;
   logic             push_valid, pop;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette      <= {{3{24'h000000}}, PAL0_RESET};
         cfg_ff.width_is_32  <= 1'b0;
         cfg_ff.sprite_lines <= LINES_RESET;
         cfg_ff.double_mode  <= 1'b0;
         cfg_ff.hires_source <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAL0, CSR_PAL1, CSR_PAL2, CSR_PAL3: begin
               cfg_ff.palette[csr_index[1:0]] <= csr_wdata;
            end
            CSR_WIDE:   cfg_ff.width_is_32  <= csr_wdata[0];
            CSR_LINES:  cfg_ff.sprite_lines <= csr_wdata[LINES_W-1:0];
            CSR_DOUBLE: cfg_ff.double_mode  <= csr_wdata[0];
            CSR_HIRES:  cfg_ff.hires_source <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   bsrgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .q_status   (q_status),
      .push_job   (push_job),
      .push_valid (push_valid)
   );

   bsrgb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   bsrgb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop_job  (pop_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

[rtl/core/bsrgb_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsrgb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsrgb_pkg::cfg_type cfg,
   bsrgb_req_if.sink              req,
   input  wire bsrgb_pkg::queue_status_type q_status,
   output bsrgb_pkg::job_type     push_job,
   output logic                   push_valid
);
   import bsrgb_pkg::*;

   logic [7:0][7:0]    bytes_ff, bytes_in;
   logic [2:0]         pos_ff, pos_in;
   logic [LINES_W-1:0] src_ff, src_in;

   logic [2:0]         pos;
   logic [LINES_W-1:0] src;
   logic               long_line;
   logic               line_done;
   logic [LINES_W:0]   height;
   logic               emit;
   logic               accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      pos = req.new_image ? '0 : pos_ff;
      src = req.new_image ? '0 : src_ff;
      long_line = cfg.double_mode ? cfg.hires_source : cfg.width_is_32;
      line_done = long_line ? (pos == 3'd7) : (pos >= 3'd3);
      height = ({1'b0, cfg.sprite_lines} > (LINES_W+1)'(STORE_HEIGHT)) ?
               (LINES_W+1)'(STORE_HEIGHT) : {1'b0, cfg.sprite_lines};
      // double mode: each source line fills two rows
      emit = cfg.double_mode ? ({1'b0, src} < (height >> 1)) : ({1'b0, src} < height);

      bytes_in      = bytes_ff;
      bytes_in[pos] = req.data_byte;
      pos_in        = pos_ff;
      src_in        = src_ff;
      if (accept) begin
         if (line_done) begin
            pos_in = '0;
            src_in = (src == '1) ? src : src + 1'b1;
         end else begin
            pos_in = pos + 1'b1;
            src_in = src;
         end
      end

      push_valid         = accept && line_done && emit;
      push_job.bytes     = bytes_in;
      push_job.src_line  = src;
      push_job.long_line = long_line;
      push_job.dbl       = cfg.double_mode;
      push_job.wide      = cfg.width_is_32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         src_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         src_ff <= src_in;
      end
      if (accept) bytes_ff <= bytes_in;
   end

endmodule

`default_nettype wire

[rtl/core/bsrgb_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsrgb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bsrgb_pkg::job_type push_job,
   input  wire logic              pop,
   output bsrgb_pkg::job_type     pop_job,
   output bsrgb_pkg::queue_status_type status
);
   import bsrgb_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      pop_job      = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) entry_ff[wr_ff] <= push_job;
   end

endmodule

`default_nettype wire

[rtl/core/bsrgb_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsrgb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsrgb_pkg::cfg_type cfg,
   input  wire bsrgb_pkg::job_type pop_job,
   input  wire bsrgb_pkg::queue_status_type q_status,
   output logic                   pop,
   bsrgb_rsp_if.source            rsp
);
   import bsrgb_pkg::*;

   job_type              job_ff;
   logic                 busy_ff, busy_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 valid_ff, valid_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 last_ff, last_in;

   logic                 advance;
   logic [4:0]           src_col;
   logic [LINES_W:0]     row;
   logic [2:0]           k0, k1;
   logic [2:0]           bit_sel;
   logic [1:0]           code;
   logic                 is_last;

   assign pop     = !busy_ff && !q_status.empty;
   assign advance = busy_ff && (!valid_ff || rsp.ready);

   always_comb begin
      // double mode: count bit 5 picks the row of the pair, bits 4:1 the source pixel
      if (job_ff.dbl) begin
         src_col = {1'b0, cnt_ff[4:1]};
         row     = {job_ff.src_line, cnt_ff[5]};
         is_last = (cnt_ff == 6'd63);
      end else begin
         src_col = cnt_ff[4:0];
         row     = {1'b0, job_ff.src_line};
         is_last = job_ff.wide ? (cnt_ff == 6'd31) : (cnt_ff == 6'd15);
      end
      k0      = {1'b0, src_col[4:3]};
      k1      = k0 + (job_ff.long_line ? 3'd4 : 3'd2);
      bit_sel = 3'd7 - src_col[2:0];
      code    = {job_ff.bytes[k1][bit_sel], job_ff.bytes[k0][bit_sel]};

      index_in = INDEX_W'(INDEX_W'(row) * INDEX_W'(STORE_WIDTH) + INDEX_W'(cnt_ff[4:0]));
      color_in = cfg.palette[code];
      last_in  = is_last;

      valid_in = valid_ff && !rsp.ready;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      if (advance) begin
         valid_in = 1'b1;
         cnt_in   = cnt_ff + 1'b1;
         if (is_last) busy_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      if (pop) job_ff <= pop_job;
      if (advance) begin
         index_ff <= index_in;
         color_ff <= color_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.pixel_index = index_ff;
   assign rsp.pixel_color = color_ff;
   assign rsp.last        = last_ff;

endmodule

`default_nettype wire

[rtl/core/bsrgb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsrgb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [10:0] pixel_index,
   input wire logic [23:0] pixel_color,
   input wire logic        last
);

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_index)
                                  && $stable(pixel_color) && $stable(last))
      else $error("stalled response changed");

   // every line ends on column 15 or 31
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> pixel_index[3:0] == 4'hf)
      else $error("line ended on a wrong column");

   a_in_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pixel_index < 11'd1536)
      else $error("pixel index outside the store");

endmodule

bind bitplane_sprite_to_rgb_core bsrgb_checker u_bsrgb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pixel_index (rsp_ch.pixel_index),
   .pixel_color (rsp_ch.pixel_color),
   .last        (rsp_ch.last)
);

`default_nettype wire
